[src/cdq_pkg.sv]
package cdq_pkg;

	typedef enum logic [2:0] {
		FN_INS_FRONT = 3'd0,
		FN_INS_REAR  = 3'd1,
		FN_DEL_FRONT = 3'd2,
		FN_DEL_REAR  = 3'd3,
		FN_RD_FRONT  = 3'd4,
		FN_RD_REAR   = 3'd5
	} cdq_func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP
	} cdq_state_t;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	localparam logic REG_CAPACITY = 1'b0;

	typedef struct packed {
		logic load;
		logic exec;
		logic resp;
	} cdq_cmd_t;

endpackage

[src/cdq_ram.sv]
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

[src/cdq_ctrl.sv]
module cdq_ctrl
	import cdq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output cdq_cmd_t cmd,
	output logic     busy
);

	cdq_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				state_d = start ? ST_EXEC : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy     = 1'b0;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		cmd.resp = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = start;
			end
			ST_EXEC: begin
				busy     = 1'b1;
				cmd.exec = 1'b1;
			end
			ST_RESP: begin
				cmd.resp = 1'b1;
				cmd.load = start;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

[src/cdq_datapath.sv]
module cdq_datapath
	import cdq_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32,
	parameter int PTR_W      = $clog2(DEPTH),
	parameter int CNT_W      = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cdq_cmd_t              cmd,
	input  logic [2:0]            func,
	input  logic [DATA_WIDTH-1:0] element_in,
	input  logic [CNT_W-1:0]      cap,
	output logic [DATA_WIDTH-1:0] element_out,
	output logic [1:0]            status,
	output logic [CNT_W-1:0]      entries_held
);

	logic [2:0]            func_q;
	logic [DATA_WIDTH-1:0] elem_q;
	logic [PTR_W-1:0]      head_q, head_d;
	logic [PTR_W-1:0]      tail_q, tail_d;
	logic [CNT_W-1:0]      fill_q, fill_d;
	logic [1:0]            status_q, status_d;
	logic                  rd_ok_q, rd_ok_d;

	logic                  ram_en, ram_we;
	logic [PTR_W-1:0]      ram_addr;
	logic [DATA_WIDTH-1:0] ram_rdata;

	logic                  is_full, is_empty;
	logic [PTR_W-1:0]      cap_m1, head_prev, tail_prev, head_next, tail_next;

	assign is_full   = fill_q >= cap;
	assign is_empty  = fill_q == '0;
	assign cap_m1    = PTR_W'(cap - CNT_W'(1));
	assign head_prev = (head_q == '0) ? cap_m1 : head_q - PTR_W'(1);
	assign tail_prev = (tail_q == '0) ? cap_m1 : tail_q - PTR_W'(1);
	assign head_next = ((CNT_W'(head_q) + CNT_W'(1)) >= cap) ? '0 : head_q + PTR_W'(1);
	assign tail_next = ((CNT_W'(tail_q) + CNT_W'(1)) >= cap) ? '0 : tail_q + PTR_W'(1);

	// hold the request until the execute cycle
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			elem_q <= element_in;
		end
	end

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		fill_d   = fill_q;
		status_d = STAT_DONE;
		rd_ok_d  = 1'b0;
		ram_en   = 1'b0;
		ram_we   = 1'b0;
		ram_addr = head_q;
		unique case (cdq_func_t'(func_q)) inside
			FN_INS_FRONT: begin
				if (is_full) begin
					status_d = STAT_FULL;
				end else begin
					head_d   = is_empty ? cap_m1 : head_prev;
					ram_en   = 1'b1;
					ram_we   = 1'b1;
					ram_addr = head_d;
					fill_d   = fill_q + CNT_W'(1);
				end
			end
			FN_INS_REAR: begin
				if (is_full) begin
					status_d = STAT_FULL;
				end else begin
					if (is_empty) head_d = '0;
					ram_en   = 1'b1;
					ram_we   = 1'b1;
					ram_addr = tail_q;
					tail_d   = tail_next;
					fill_d   = fill_q + CNT_W'(1);
				end
			end
			FN_DEL_FRONT, FN_DEL_REAR: begin
				if (is_empty) begin
					status_d = STAT_EMPTY;
				end else begin
					if (cdq_func_t'(func_q) == FN_DEL_FRONT) begin
						head_d = head_next;
					end else begin
						tail_d = tail_prev;
					end
					fill_d = fill_q - CNT_W'(1);
					// return both indices to the empty position
					if (fill_q == CNT_W'(1)) begin
						head_d = '0;
						tail_d = '0;
					end
				end
			end
			FN_RD_FRONT, FN_RD_REAR: begin
				if (is_empty) begin
					status_d = STAT_EMPTY;
				end else begin
					rd_ok_d  = 1'b1;
					ram_en   = 1'b1;
					ram_addr = (cdq_func_t'(func_q) == FN_RD_FRONT) ? head_q : tail_prev;
				end
			end
			default: begin
				status_d = STAT_DONE;
			end
		endcase
		if (!cmd.exec) begin
			ram_en = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			fill_q   <= '0;
			status_q <= STAT_DONE;
			rd_ok_q  <= 1'b0;
		end else if (cmd.exec) begin
			head_q   <= head_d;
			tail_q   <= tail_d;
			fill_q   <= fill_d;
			status_q <= status_d;
			rd_ok_q  <= rd_ok_d;
		end
	end

	cdq_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(elem_q),
		.rdata(ram_rdata)
	);

	assign element_out  = rd_ok_q ? ram_rdata : '0;
	assign status       = status_q;
	assign entries_held = fill_q;

`ifndef SYNTHESIS
	a_fill_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cap)
		else $error("fill count above capacity");
	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) |-> (head_q == '0 && tail_q == '0))
		else $error("indices not parked while empty");
	a_fill_exec_only: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.exec |=> $stable(fill_q))
		else $error("fill count moved outside execute");
`endif

endmodule

[src/circular_deque.sv]
// Double-ended queue on a ring of DEPTH entries of DATA_WIDTH bits.
//
// Request channel: drive func and element_in with start high; the request
// transfers at the rising edge where start is high and busy is low. busy is
// high in the execute state that follows a transfer, while the request executes.
// Result channel: done is high for exactly one cycle, in the result state that
// follows the execute state, with element_out, status and entries_held. The
// receiver cannot stall; the result holds only until the next request executes.
// The execute cycle touches the single-port ring memory at most once; its registered
// read feeds the result cycle, and a new request may transfer during that
// result cycle.
// Configuration: APB register 0 (capacity_in_use, byte address 0). Writes
// land only while the queue is empty; of the low CNT_W bits, 0 is taken as 1
// and above DEPTH as DEPTH. pready is always high; reads return the capacity
// in use. Reset: queue empty, indices at zero, capacity min(16, DEPTH). Ring
// contents stay undefined until written; no read ever reaches such an entry.
module circular_deque
	import cdq_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [2:0]                   func,
	input  logic signed [DATA_WIDTH-1:0] element_in,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] element_out,
	output logic [1:0]                   status,
	output logic [$clog2(DEPTH+1)-1:0]   entries_held,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] CAP_RST = CNT_W'((DEPTH < 16) ? DEPTH : 16);

	cdq_cmd_t         cmd;
	logic [CNT_W-1:0] cap_q;
	logic [CNT_W-1:0] cap_wr;
	logic             cfg_wr;
	logic             req_xfer;

	assign pready   = 1'b1;
	assign req_xfer = start && !busy;

	// clamp the written capacity to 1..DEPTH
	always_comb begin
		cap_wr = pwdata[CNT_W-1:0];
		if (cap_wr == '0) begin
			cap_wr = CNT_W'(1);
		end else if (cap_wr > CNT_W'(DEPTH)) begin
			cap_wr = CNT_W'(DEPTH);
		end
	end

	// drop capacity writes while the queue holds anything
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)
		&& (entries_held == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RST;
		end else if (cfg_wr) begin
			cap_q <= cap_wr;
		end
	end

	assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32 - CNT_W){1'b0}}, cap_q} : '0;

	cdq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.busy  (busy)
	);

	cdq_datapath #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.func        (func),
		.element_in  (element_in),
		.cap         (cap_q),
		.element_out (element_out),
		.status      (status),
		.entries_held(entries_held)
	);

	assign done = cmd.resp;

`ifndef SYNTHESIS
	a_done_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(req_xfer, 2))
		else $error("result without a request transfer two cycles earlier");
`endif

endmodule
